// ===== hw/rtl/bfiq_pkg.sv =====
package bfiq_pkg;

  localparam int unsigned FILTER_BITS_DEF = 65536;
  localparam int unsigned MAX_PROBES_DEF  = 20;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned KCFG_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] BITS_RESET  = 17'd65536;
  localparam logic [KCFG_W-1:0]     PROBE_RESET = 5'd7;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] h1;
  } job_t;

  // FNV-1a step; prime is 2^40 + 0x1B3, so the product is shifts and adds
  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// ===== hw/rtl/bfiq_ram.sv =====
module bfiq_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bfiq_front.sv =====
module bfiq_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       key_byte,
  input  logic             has_byte,
  input  logic             key_last,
  input  logic             op,
  output logic             push,
  output bfiq_pkg::job_t   job
);

  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] folded;

  assign folded = has_byte ? bfiq_pkg::fnv_fold(hash_r, key_byte) : hash_r;

  always_comb begin
    hash_nxt = hash_r;
    if (accept) begin
      hash_nxt = key_last ? bfiq_pkg::FNV_BASIS : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= bfiq_pkg::FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign push   = accept && key_last;
  assign job.op = bfiq_pkg::op_t'(op);
  assign job.h1 = folded;

endmodule

// ===== hw/rtl/bfiq_queue.sv =====
module bfiq_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bfiq_pkg::job_t wr_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bfiq_pkg::job_t rd_job
);

  bfiq_pkg::job_t slot_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign rd_job    = slot_r[rp_r];

endmodule

// ===== hw/rtl/bfiq_back.sv =====
module bfiq_back #(
  parameter int unsigned FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
  parameter int unsigned MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF,
  localparam int unsigned AW = $clog2(FILTER_BITS),
  localparam int unsigned MW = $clog2(FILTER_BITS + 1),
  localparam int unsigned PW = $clog2(MAX_PROBES + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [MW-1:0]  m_used,
  input  logic [PW-1:0]  k_used,
  input  logic           job_valid,
  input  bfiq_pkg::job_t job,
  output logic           job_pop,
  output logic           clearing,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_maybe_present
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_H2, S_MOD, S_ACC, S_CHK, S_RES
  } state_t;

  state_t           st_r;
  logic [AW-1:0]    clr_addr_r;
  logic [63:0]      h1_r, h2_r, acc_r, div_r;
  logic [MW-1:0]    rem_r, m_r;
  logic [PW-1:0]    probe_r, k_r;
  logic [5:0]       step_r;
  bfiq_pkg::op_t    op_r;
  logic             all_r;
  logic             out_valid_r, out_maybe_r;

  logic [MW:0]      trial;
  logic             ge;
  logic [MW-1:0]    rem_nxt;
  logic [63:0]      acc_nxt;
  logic             ram_we, ram_wd, ram_rd;
  logic [AW-1:0]    ram_addr;

  assign trial   = {rem_r, div_r[63]};
  assign ge      = trial >= {1'b0, m_r};
  assign rem_nxt = ge ? MW'(trial - {1'b0, m_r}) : MW'(trial);
  assign acc_nxt = acc_r + h2_r;

  assign ram_we   = (st_r == S_CLR) || (st_r == S_ACC && op_r == bfiq_pkg::OP_INSERT);
  assign ram_wd   = st_r != S_CLR;
  assign ram_addr = (st_r == S_CLR) ? clr_addr_r : rem_r[AW-1:0];

  bfiq_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_rd)
  );

  assign job_pop = (st_r == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && st_r != S_RES) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(FILTER_BITS - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            op_r   <= job.op;
            h1_r   <= job.h1;
            acc_r  <= job.h1;
            h2_r   <= bfiq_pkg::FNV_BASIS;
            m_r    <= m_used;
            k_r    <= k_used;
            probe_r <= '0;
            all_r  <= 1'b1;
            step_r <= '0;
            st_r   <= S_H2;
          end
        end
        S_H2: begin
          h2_r   <= bfiq_pkg::fnv_fold(h2_r, h1_r[{step_r[2:0], 3'b000} +: 8]);
          if (step_r[2:0] == 3'd7) begin
            div_r  <= acc_r;
            rem_r  <= '0;
            step_r <= '0;
            st_r   <= S_MOD;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_MOD: begin
          rem_r  <= rem_nxt;
          div_r  <= {div_r[62:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == 6'd63) st_r <= S_ACC;
        end
        S_ACC: st_r <= S_CHK;
        S_CHK: begin
          if (op_r == bfiq_pkg::OP_QUERY && !ram_rd) all_r <= 1'b0;
          probe_r <= probe_r + 1'b1;
          if (probe_r + 1'b1 == k_r) begin
            st_r <= (op_r == bfiq_pkg::OP_QUERY) ? S_RES : S_IDLE;
          end else begin
            acc_r  <= acc_nxt;
            div_r  <= acc_nxt;
            rem_r  <= '0;
            step_r <= '0;
            st_r   <= S_MOD;
          end
        end
        S_RES: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_maybe_r <= all_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign clearing          = st_r == S_CLR;
  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_maybe_r;

`ifndef SYNTH
  a_rem_below_m: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MOD || st_r == S_ACC) |-> rem_r < m_r)
    else $error("remainder not below modulus");
  a_probe_below_k: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MOD || st_r == S_CHK) |-> probe_r < k_r)
    else $error("probe index past count");
  a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> !out_valid_r && !job_pop)
    else $error("activity during clear");
  a_res_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RES && !out_valid_r) |=> out_valid_r && st_r == S_IDLE)
    else $error("result not loaded");
`endif

endmodule

// ===== hw/rtl/bloom_filter_insert_query.sv =====
// Bloom filter, insert and query, keys streamed as bytes.
// Input channel (in_valid/in_ready): one key byte per item (in_has_byte
// low adds none); in_key_last ends the key and in_op on that item picks
// insert or query. Key bytes are hashed at one item per cycle while
// in_ready is high. A key end is queued (two deep) for the probe
// engine, which takes the key, folds the first hash byte by byte into
// a second hash and then, per probe, runs a 64-bit bit-serial remainder,
// one memory access and one check; a query also passes a result state.
// Input keeps flowing until the queue is full.
// Result channel (out_valid/out_ready): one item per query, registered;
// a stalled receiver holds the result and, once the queue fills, the
// input.
// Configuration (cfg_wr_en/cfg_index/cfg_data): modulus and probe count,
// written only while idle by the user; the block does not enforce it.
// Reset: the filter memory is cleared one bit per cycle, over all
// FILTER_BITS addresses, with in_ready low throughout.
module bloom_filter_insert_query #(
  parameter int unsigned FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
  parameter int unsigned MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic [7:0]                         in_key_byte,
  input  logic                               in_has_byte,
  input  logic                               in_key_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_maybe_present,
  input  logic                               cfg_wr_en,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned MW = $clog2(FILTER_BITS + 1);
  localparam int unsigned PW = $clog2(MAX_PROBES + 1);

  logic [bfiq_pkg::CFG_DATA_W-1:0] bits_r;
  logic [bfiq_pkg::KCFG_W-1:0]     probes_r;
  logic [MW-1:0]                   m_used;
  logic [PW-1:0]                   k_used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r   <= bfiq_pkg::BITS_RESET;
      probes_r <= bfiq_pkg::PROBE_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == bfiq_pkg::CFG_BITS_IN_USE) bits_r <= cfg_data;
      if (cfg_index == bfiq_pkg::CFG_PROBE_COUNT) probes_r <= cfg_data[bfiq_pkg::KCFG_W-1:0];
    end
  end

  always_comb begin
    if (int'(bits_r) < 8)                m_used = MW'(8);
    else if (int'(bits_r) > FILTER_BITS) m_used = MW'(FILTER_BITS);
    else                                 m_used = MW'(bits_r);
    if (probes_r == '0)                    k_used = PW'(1);
    else if (int'(probes_r) > MAX_PROBES)  k_used = PW'(MAX_PROBES);
    else                                   k_used = PW'(probes_r);
  end

  logic           accept, push, full, pop, not_empty, clearing;
  bfiq_pkg::job_t wr_job, rd_job;

  assign in_ready = !full && !clearing;
  assign accept   = in_valid && in_ready;

  bfiq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .key_byte (in_key_byte),
    .has_byte (in_has_byte),
    .key_last (in_key_last),
    .op       (in_op),
    .push     (push),
    .job      (wr_job)
  );

  bfiq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_job    (wr_job),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_job    (rd_job)
  );

  bfiq_back #(.FILTER_BITS(FILTER_BITS), .MAX_PROBES(MAX_PROBES)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .m_used            (m_used),
    .k_used            (k_used),
    .job_valid         (not_empty),
    .job               (rd_job),
    .job_pop           (pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_maybe_present (out_maybe_present)
  );

endmodule
